[rtl/core/astro_pkg.sv]
// Shared constants, types and arithmetic helpers for the astroidal surface evaluator.
// Holds the quarter-wave trig tables built at elaboration. No dependencies.
`timescale 1ns / 1ps

package astro_pkg;

	localparam int ANGLE_BITS       = 16;
	localparam int TRIG_TABLE_DEPTH = 1024;
	localparam int TRIG_IDX_BITS    = $clog2(TRIG_TABLE_DEPTH);
	localparam int QUAD_BITS        = TRIG_IDX_BITS - 2;
	localparam int QDEPTH           = TRIG_TABLE_DEPTH / 4;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	localparam int VAL_W     = 18;
	localparam int MAG_W     = 17;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SCALE_W   = 16;
	localparam int SPROD_W   = VAL_W + SCALE_W + 1;
	localparam int SCL_W     = SPROD_W + 3;
	localparam int OUT_W     = 32;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_A        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT_DERIV = 8'd1;
	localparam logic [SCALE_W-1:0]   SCALE_A_RESET      = 16'd256;

	// result lanes
	localparam int NLANES  = 8;
	localparam int L_PX    = 0;
	localparam int L_PY    = 1;
	localparam int L_PZ    = 2;
	localparam int L_DXDU  = 3;
	localparam int L_DYDU  = 4;
	localparam int L_DXDV  = 5;
	localparam int L_DYDV  = 6;
	localparam int L_DZDV  = 7;

	localparam logic [NLANES-1:0] LANE_X3  = 8'b1111_1000;
	localparam logic [NLANES-1:0] LANE_NEG = 8'b0110_1000;
	localparam logic [NLANES-1:0] LANE_DU  = 8'b0001_1000;
	localparam logic [NLANES-1:0] LANE_DV  = 8'b1110_0000;

	localparam logic signed [SCL_W-1:0] SAT_HI = SCL_W'(32'h7FFF_FFFF);
	localparam logic signed [SCL_W-1:0] SAT_LO = -SAT_HI - SCL_W'(1);

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [MAG_W-1:0] quad_tbl_t [QDEPTH];
	typedef logic signed [SPROD_W-1:0] sprod_t;
	typedef logic [OUT_W-1:0] res_t;

	function automatic logic [63:0] series_step(input logic [63:0] term, input logic [63:0] x2);
		return (term * x2) >> 30;
	endfunction

	function automatic logic [MAG_W-1:0] q30_to_q16(input logic signed [63:0] s);
		logic [63:0] rnd;
		rnd = (s < 0) ? 64'd8192 : ($unsigned(s) + 64'd8192);
		return rnd[MAG_W+13:14];
	endfunction

	function automatic logic [MAG_W-1:0] sin_series(input logic [63:0] phi);
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [63:0] s;
		x2 = (phi * phi) >> 30;
		t = phi;
		s = $signed(t);
		t = series_step(t, x2) / 64'd6;   s = s - $signed(t);
		t = series_step(t, x2) / 64'd20;  s = s + $signed(t);
		t = series_step(t, x2) / 64'd42;  s = s - $signed(t);
		t = series_step(t, x2) / 64'd72;  s = s + $signed(t);
		t = series_step(t, x2) / 64'd110; s = s - $signed(t);
		t = series_step(t, x2) / 64'd156; s = s + $signed(t);
		t = series_step(t, x2) / 64'd210; s = s - $signed(t);
		t = series_step(t, x2) / 64'd272; s = s + $signed(t);
		t = series_step(t, x2) / 64'd342; s = s - $signed(t);
		t = series_step(t, x2) / 64'd420; s = s + $signed(t);
		t = series_step(t, x2) / 64'd506; s = s - $signed(t);
		t = series_step(t, x2) / 64'd600; s = s + $signed(t);
		return q30_to_q16(s);
	endfunction

	function automatic logic [MAG_W-1:0] cos_series(input logic [63:0] phi);
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [63:0] s;
		x2 = (phi * phi) >> 30;
		t = ONE_Q30;
		s = $signed(t);
		t = series_step(t, x2) / 64'd2;   s = s - $signed(t);
		t = series_step(t, x2) / 64'd12;  s = s + $signed(t);
		t = series_step(t, x2) / 64'd30;  s = s - $signed(t);
		t = series_step(t, x2) / 64'd56;  s = s + $signed(t);
		t = series_step(t, x2) / 64'd90;  s = s - $signed(t);
		t = series_step(t, x2) / 64'd132; s = s + $signed(t);
		t = series_step(t, x2) / 64'd182; s = s - $signed(t);
		t = series_step(t, x2) / 64'd240; s = s + $signed(t);
		t = series_step(t, x2) / 64'd306; s = s - $signed(t);
		t = series_step(t, x2) / 64'd380; s = s + $signed(t);
		t = series_step(t, x2) / 64'd462; s = s - $signed(t);
		t = series_step(t, x2) / 64'd552; s = s + $signed(t);
		return q30_to_q16(s);
	endfunction

	function automatic logic [63:0] quad_phi(input int r);
		return ((PI_Q30 / 2) * 64'(r)) / QDEPTH;
	endfunction

	function automatic quad_tbl_t build_sin_tbl();
		quad_tbl_t tbl;
		for (int r = 0; r < QDEPTH; r++) begin
			tbl[r] = sin_series(quad_phi(r));
		end
		return tbl;
	endfunction

	function automatic quad_tbl_t build_cos_tbl();
		quad_tbl_t tbl;
		for (int r = 0; r < QDEPTH; r++) begin
			tbl[r] = cos_series(quad_phi(r));
		end
		return tbl;
	endfunction

	localparam quad_tbl_t SIN_TBL = build_sin_tbl();
	localparam quad_tbl_t COS_TBL = build_cos_tbl();

	// full-turn sine from quadrant and quarter index
	function automatic val_t trig_val(input logic [1:0] q, input logic [QUAD_BITS-1:0] r);
		val_t s_v;
		val_t c_v;
		s_v = val_t'({1'b0, SIN_TBL[r]});
		c_v = val_t'({1'b0, COS_TBL[r]});
		case (q)
			2'd0: return s_v;
			2'd1: return c_v;
			2'd2: return -s_v;
			2'd3: return -c_v;
			default: return s_v;
		endcase
	endfunction

	// Q16 product, rounded half away from zero
	function automatic val_t mulq(input val_t a, input val_t b);
		logic signed [PROD_W-1:0] p;
		logic [PROD_W-1:0] m;
		p = a * b;
		m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		m = (m + PROD_W'(32768)) >> 16;
		return p[PROD_W-1] ? -val_t'(m[VAL_W-1:0]) : val_t'(m[VAL_W-1:0]);
	endfunction

	// round by 2^8 half away from zero, optional sign flip, saturate to 32 bits
	function automatic res_t scale_round(input logic signed [SCL_W-1:0] v, input logic neg);
		logic [SCL_W-1:0] m;
		logic signed [SCL_W-1:0] r;
		m = v[SCL_W-1] ? SCL_W'(-v) : SCL_W'(v);
		m = (m + SCL_W'(128)) >> 8;
		r = (v[SCL_W-1] ^ neg) ? -$signed(m) : $signed(m);
		if (r > SAT_HI)
			return 32'h7FFF_FFFF;
		else if (r < SAT_LO)
			return 32'h8000_0000;
		else
			return r[OUT_W-1:0];
	endfunction

endpackage

[rtl/core/astroidal_surface_point_eval_top.sv]
// Top level of the astroidal surface point evaluator: six-stage pipeline.
// Depends on astro_pkg for tables, constants and fixed-point helpers.
`timescale 1ns / 1ps

// Usage
//   Input channel: angle_u, angle_v, want_du, want_dv with in_valid/in_stall.
//   A transaction is taken at a rising edge with in_valid high and in_stall low.
//   Output channel: pos_*, d*_du, d*_dv, du_valid, dv_valid with out_valid/out_stall.
//   Config channel: cfg_valid/cfg_ready (ready is always high), cfg_index selects
//   scale_a (0) or explicit_derivatives (1); other indexes are dropped.
//   Write config only while the pipeline is empty.
// Path: stage 1 loads at the accepting edge; the result then moves through
//   stages 2 to 6 and waits in the output register (stage 6) until taken.
// Throughput: one transaction per cycle while not stalled; six register
//   stages (table lookup, squares, cubes, cross products, scale multiply,
//   round/saturate), each at most one 18x18 or 17x18 multiplier deep per lane.
// Reset: all stage valid bits clear; scale_a = 1.0 (256), derivatives enabled.
// Stall: out_stall holds the output register; stages behind it keep filling
//   bubbles, and in_stall rises only once every stage holds a transaction.
//   Nothing is dropped or repeated.
module astroidal_surface_point_eval_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [astro_pkg::ANGLE_BITS-1:0]     angle_u,
	input  logic [astro_pkg::ANGLE_BITS-1:0]     angle_v,
	input  logic                                 want_du,
	input  logic                                 want_dv,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [astro_pkg::OUT_W-1:0]   pos_x,
	output logic signed [astro_pkg::OUT_W-1:0]   pos_y,
	output logic signed [astro_pkg::OUT_W-1:0]   pos_z,
	output logic signed [astro_pkg::OUT_W-1:0]   dx_du,
	output logic signed [astro_pkg::OUT_W-1:0]   dy_du,
	output logic signed [astro_pkg::OUT_W-1:0]   dz_du,
	output logic signed [astro_pkg::OUT_W-1:0]   dx_dv,
	output logic signed [astro_pkg::OUT_W-1:0]   dy_dv,
	output logic signed [astro_pkg::OUT_W-1:0]   dz_dv,
	output logic                                 du_valid,
	output logic                                 dv_valid,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [astro_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [astro_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [astro_pkg::SCALE_W-1:0] scale_a_q;
	logic                          expl_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	logic [astro_pkg::TRIG_IDX_BITS-1:0] idx_u, idx_v;
	logic [1:0] qu, qv;

	astro_pkg::val_t su_s1, cu_s1, sv_s1, cv_s1;
	logic du_s1, dv_s1;

	astro_pkg::val_t su_s2, cu_s2, sv_s2, cv_s2, su2_s2, cu2_s2, sv2_s2, cv2_s2;
	logic du_s2, dv_s2;

	astro_pkg::val_t su3_s3, cu3_s3, sv3_s3, cv3_s3, svcv2_s3, sucu2_s3, su2cu_s3;
	astro_pkg::val_t sv2_s3, cv_s3;
	logic du_s3, dv_s3;

	astro_pkg::val_t t_s4 [astro_pkg::NLANES];
	logic du_s4, dv_s4;

	astro_pkg::sprod_t p_s5 [astro_pkg::NLANES];
	logic du_s5, dv_s5;

	astro_pkg::res_t res_c [astro_pkg::NLANES];
	astro_pkg::res_t res_s6 [astro_pkg::NLANES];
	logic du_s6, dv_s6;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_a_q <= astro_pkg::SCALE_A_RESET;
			expl_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				astro_pkg::REG_SCALE_A:        scale_a_q <= cfg_data[astro_pkg::SCALE_W-1:0];
				astro_pkg::REG_EXPLICIT_DERIV: expl_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// flow control
	assign adv6 = !v_s6 || !out_stall;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// stage 1: table lookup
	assign idx_u = angle_u[astro_pkg::ANGLE_BITS-1 -: astro_pkg::TRIG_IDX_BITS];
	assign idx_v = angle_v[astro_pkg::ANGLE_BITS-1 -: astro_pkg::TRIG_IDX_BITS];
	assign qu = idx_u[astro_pkg::TRIG_IDX_BITS-1 -: 2];
	assign qv = idx_v[astro_pkg::TRIG_IDX_BITS-1 -: 2];

	always_ff @(posedge clk) begin
		if (adv1) begin
			su_s1 <= astro_pkg::trig_val(qu, idx_u[astro_pkg::QUAD_BITS-1:0]);
			cu_s1 <= astro_pkg::trig_val(qu + 2'd1, idx_u[astro_pkg::QUAD_BITS-1:0]);
			sv_s1 <= astro_pkg::trig_val(qv, idx_v[astro_pkg::QUAD_BITS-1:0]);
			cv_s1 <= astro_pkg::trig_val(qv + 2'd1, idx_v[astro_pkg::QUAD_BITS-1:0]);
			du_s1 <= expl_q && want_du;
			dv_s1 <= expl_q && want_dv;
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (adv2) begin
			su_s2  <= su_s1;
			cu_s2  <= cu_s1;
			sv_s2  <= sv_s1;
			cv_s2  <= cv_s1;
			su2_s2 <= astro_pkg::mulq(su_s1, su_s1);
			cu2_s2 <= astro_pkg::mulq(cu_s1, cu_s1);
			sv2_s2 <= astro_pkg::mulq(sv_s1, sv_s1);
			cv2_s2 <= astro_pkg::mulq(cv_s1, cv_s1);
			du_s2  <= du_s1;
			dv_s2  <= dv_s1;
		end
	end

	// stage 3: cubes and mixed terms
	always_ff @(posedge clk) begin
		if (adv3) begin
			su3_s3   <= astro_pkg::mulq(su2_s2, su_s2);
			cu3_s3   <= astro_pkg::mulq(cu2_s2, cu_s2);
			sv3_s3   <= astro_pkg::mulq(sv2_s2, sv_s2);
			cv3_s3   <= astro_pkg::mulq(cv2_s2, cv_s2);
			svcv2_s3 <= astro_pkg::mulq(sv_s2, cv2_s2);
			sucu2_s3 <= astro_pkg::mulq(su_s2, cu2_s2);
			su2cu_s3 <= astro_pkg::mulq(su2_s2, cu_s2);
			sv2_s3   <= sv2_s2;
			cv_s3    <= cv_s2;
			du_s3    <= du_s2;
			dv_s3    <= dv_s2;
		end
	end

	// stage 4: lane terms
	always_ff @(posedge clk) begin
		if (adv4) begin
			t_s4[astro_pkg::L_PX]   <= astro_pkg::mulq(cu3_s3, cv3_s3);
			t_s4[astro_pkg::L_PY]   <= astro_pkg::mulq(su3_s3, cv3_s3);
			t_s4[astro_pkg::L_PZ]   <= sv3_s3;
			t_s4[astro_pkg::L_DXDU] <= astro_pkg::mulq(sucu2_s3, cv3_s3);
			t_s4[astro_pkg::L_DYDU] <= astro_pkg::mulq(su2cu_s3, cv3_s3);
			t_s4[astro_pkg::L_DXDV] <= astro_pkg::mulq(cu3_s3, svcv2_s3);
			t_s4[astro_pkg::L_DYDV] <= astro_pkg::mulq(su3_s3, svcv2_s3);
			t_s4[astro_pkg::L_DZDV] <= astro_pkg::mulq(sv2_s3, cv_s3);
			du_s4 <= du_s3;
			dv_s4 <= dv_s3;
		end
	end

	// stage 5: multiply by a
	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int l = 0; l < astro_pkg::NLANES; l++) begin
				p_s5[l] <= $signed({1'b0, scale_a_q}) * t_s4[l];
			end
			du_s5 <= du_s4;
			dv_s5 <= dv_s4;
		end
	end

	// stage 6: coefficient, rounding, saturation, gating
	always_comb begin
		logic signed [astro_pkg::SCL_W-1:0] v;
		logic signed [astro_pkg::SCL_W-1:0] v3;
		for (int l = 0; l < astro_pkg::NLANES; l++) begin
			v  = astro_pkg::SCL_W'(p_s5[l]);
			v3 = astro_pkg::LANE_X3[l] ? (v + (v <<< 1)) : v;
			if ((astro_pkg::LANE_DU[l] && !du_s5) || (astro_pkg::LANE_DV[l] && !dv_s5))
				res_c[l] = '0;
			else
				res_c[l] = astro_pkg::scale_round(v3, astro_pkg::LANE_NEG[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			for (int l = 0; l < astro_pkg::NLANES; l++) begin
				res_s6[l] <= res_c[l];
			end
			du_s6 <= du_s5;
			dv_s6 <= dv_s5;
		end
	end

	assign out_valid = v_s6;
	assign pos_x     = res_s6[astro_pkg::L_PX];
	assign pos_y     = res_s6[astro_pkg::L_PY];
	assign pos_z     = res_s6[astro_pkg::L_PZ];
	assign dx_du     = res_s6[astro_pkg::L_DXDU];
	assign dy_du     = res_s6[astro_pkg::L_DYDU];
	assign dz_du     = '0;
	assign dx_dv     = res_s6[astro_pkg::L_DXDV];
	assign dy_dv     = res_s6[astro_pkg::L_DYDV];
	assign dz_dv     = res_s6[astro_pkg::L_DZDV];
	assign du_valid  = du_s6;
	assign dv_valid  = dv_s6;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_valid && out_stall))
		else $error("input stalled while a pipeline stage is empty");

	a_du_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !du_valid) |-> (dx_du == '0 && dy_du == '0))
		else $error("u derivatives nonzero while not valid");

	a_dv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dv_valid) |-> (dx_dv == '0 && dy_dv == '0 && dz_dv == '0))
		else $error("v derivatives nonzero while not valid");

	a_out_moves_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !v_s5) |=> !out_valid)
		else $error("output transaction repeated");

endmodule
